### design/tqh_pkg.sv
// shared types and codes for the ticket queue with history stack
// no dependencies; imported by every module of the block
package tqh_pkg;

  // field widths of one word
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned PID_W   = 32;
  localparam int unsigned TRAIN_W = 16;
  localparam int unsigned FARE_W  = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned QCNT_W  = 8;
  localparam int unsigned HCNT_W  = 7;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ENQUEUE   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PROCESS   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CANCEL    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PEEK_Q    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PEEK_HIST = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_QUEUE_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_QUEUE_EMPT = 2'd2;
  localparam logic [STAT_W-1:0] ST_HIST_EMPT  = 2'd3;

  // one booking record
  typedef struct packed {
    logic [PID_W-1:0]   pid;
    logic [TRAIN_W-1:0] train;
    logic [FARE_W-1:0]  fare;
  } rec_t;

  // which record goes out with the result
  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_QUEUE,
    SEL_HIST
  } rec_sel_t;

  // controller to datapath
  typedef struct packed {
    logic              capture;
    logic              commit;
    logic              q_push;
    logic              q_pop;
    logic              h_push;
    logic              h_pop;
    rec_sel_t          rec_sel;
    logic [STAT_W-1:0] status;
    logic              saved;
  } tqh_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic q_empty;
    logic q_full;
    logic h_empty;
    logic h_full;
  } tqh_flags_t;

endpackage

### design/tqh_ctrl.sv
// request sequencer: takes a request, then issues one commit cycle
// depends on tqh_pkg
module tqh_ctrl
  import tqh_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [REQ_W-1:0] in_req_type,
  input  tqh_flags_t       flags,
  output tqh_cmd_t         cmd,
  output logic             busy,
  output logic             out_valid
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t           state_r;
  logic [REQ_W-1:0] req_r;
  logic             out_valid_r;

  // state, latched request and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      req_r       <= '0;
    end else begin
      out_valid_r <= (state_r == S_EXEC);
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_EXEC;
            req_r   <= in_req_type;
          end
        end
        S_EXEC: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // request decode into datapath commands
  always_comb begin
    cmd         = '0;
    cmd.rec_sel = SEL_NONE;
    cmd.status  = ST_OK;
    cmd.capture = (state_r == S_IDLE) && start;
    cmd.commit  = (state_r == S_EXEC);
    if (state_r == S_EXEC) begin
      case (req_r)
        REQ_ENQUEUE: begin
          if (flags.q_full) cmd.status = ST_QUEUE_FULL;
          else cmd.q_push = 1'b1;
        end
        REQ_PROCESS: begin
          if (flags.q_empty) begin
            cmd.status = ST_QUEUE_EMPT;
          end else begin
            cmd.q_pop   = 1'b1;
            cmd.rec_sel = SEL_QUEUE;
            // history full: head still leaves, push skipped
            if (!flags.h_full) begin
              cmd.h_push = 1'b1;
              cmd.saved  = 1'b1;
            end
          end
        end
        REQ_CANCEL: begin
          if (flags.h_empty) begin
            cmd.status = ST_HIST_EMPT;
          end else begin
            cmd.h_pop   = 1'b1;
            cmd.rec_sel = SEL_HIST;
          end
        end
        REQ_PEEK_Q: begin
          if (flags.q_empty) cmd.status = ST_QUEUE_EMPT;
          else cmd.rec_sel = SEL_QUEUE;
        end
        REQ_PEEK_HIST: begin
          if (flags.h_empty) cmd.status = ST_HIST_EMPT;
          else cmd.rec_sel = SEL_HIST;
        end
        default: begin
          cmd.status = ST_OK;
        end
      endcase
    end
  end

endmodule

### design/tqh_dp.sv
// datapath: queue ring memory, history stack memory, counts, result registers
// depends on tqh_pkg; driven by tqh_ctrl
module tqh_dp
  import tqh_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH   = 128,
  parameter int unsigned HISTORY_SLOTS = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tqh_cmd_t           cmd,
  input  logic [PID_W-1:0]   in_passenger_id,
  input  logic [TRAIN_W-1:0] in_train_number,
  input  logic [FARE_W-1:0]  in_fare,
  output tqh_flags_t         flags,
  output logic [STAT_W-1:0]  out_status,
  output logic [PID_W-1:0]   out_rec_passenger,
  output logic [TRAIN_W-1:0] out_rec_train,
  output logic [FARE_W-1:0]  out_rec_fare,
  output logic               out_history_saved,
  output logic [QCNT_W-1:0]  out_queue_count,
  output logic [HCNT_W-1:0]  out_history_count
);

  localparam int unsigned HIST_CAP = HISTORY_SLOTS - 1;
  localparam int unsigned QI_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned QF_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned HF_W     = $clog2(HISTORY_SLOTS);
  localparam int unsigned HI_W     = (HIST_CAP > 1) ? $clog2(HIST_CAP) : 1;

  rec_t q_mem [QUEUE_DEPTH];
  rec_t h_mem [HIST_CAP];

  rec_t            in_rec_r;
  rec_t            q_rd_r;
  rec_t            h_rd_r;
  logic [QI_W-1:0] q_head_r, q_head_nxt;
  logic [QI_W-1:0] q_tail_r, q_tail_nxt;
  logic [QF_W-1:0] q_fill_r, q_fill_nxt;
  logic [HF_W-1:0] h_fill_r, h_fill_nxt;
  logic [HI_W-1:0] h_top_idx;
  logic [HI_W-1:0] h_wr_idx;
  rec_t            rec_sel_val;
  logic [QF_W+QCNT_W-1:0] q_cnt_ext;
  logic [HF_W+HCNT_W-1:0] h_cnt_ext;

  // status flags
  assign flags.q_empty = (q_fill_r == '0);
  assign flags.q_full  = (q_fill_r == QF_W'(QUEUE_DEPTH));
  assign flags.h_empty = (h_fill_r == '0);
  assign flags.h_full  = (h_fill_r == HF_W'(HIST_CAP));

  // history addresses: top entry for read, next free entry for write
  assign h_top_idx = flags.h_empty ? '0 : HI_W'(h_fill_r - 1'b1);
  assign h_wr_idx  = HI_W'(h_fill_r);

  // capture the incoming word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_rec_r.pid   <= in_passenger_id;
      in_rec_r.train <= in_train_number;
      in_rec_r.fare  <= in_fare;
    end
  end

  // queue ring memory: head read on capture, tail write on commit
  always_ff @(posedge clk) begin
    if (cmd.capture) q_rd_r <= q_mem[q_head_r];
    if (cmd.commit && cmd.q_push) q_mem[q_tail_r] <= in_rec_r;
  end

  // history stack memory: top read on capture, push on commit
  always_ff @(posedge clk) begin
    if (cmd.capture) h_rd_r <= h_mem[h_top_idx];
    if (cmd.commit && cmd.h_push) h_mem[h_wr_idx] <= q_rd_r;
  end

  // pointer and count updates
  always_comb begin
    q_head_nxt = q_head_r;
    q_tail_nxt = q_tail_r;
    q_fill_nxt = q_fill_r;
    h_fill_nxt = h_fill_r;
    if (cmd.commit) begin
      if (cmd.q_push) begin
        q_tail_nxt = (q_tail_r == QI_W'(QUEUE_DEPTH - 1)) ? '0 : q_tail_r + 1'b1;
        q_fill_nxt = q_fill_r + 1'b1;
      end
      if (cmd.q_pop) begin
        q_head_nxt = (q_head_r == QI_W'(QUEUE_DEPTH - 1)) ? '0 : q_head_r + 1'b1;
        q_fill_nxt = q_fill_r - 1'b1;
      end
      if (cmd.h_push) h_fill_nxt = h_fill_r + 1'b1;
      if (cmd.h_pop)  h_fill_nxt = h_fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_head_r <= '0;
      q_tail_r <= '0;
      q_fill_r <= '0;
      h_fill_r <= '0;
    end else begin
      q_head_r <= q_head_nxt;
      q_tail_r <= q_tail_nxt;
      q_fill_r <= q_fill_nxt;
      h_fill_r <= h_fill_nxt;
    end
  end

  // record for the result word
  always_comb begin
    case (cmd.rec_sel)
      SEL_QUEUE: rec_sel_val = q_rd_r;
      SEL_HIST:  rec_sel_val = h_rd_r;
      default:   rec_sel_val = '0;
    endcase
  end

  // counts masked to the result field widths
  assign q_cnt_ext = {{QCNT_W{1'b0}}, q_fill_nxt};
  assign h_cnt_ext = {{HCNT_W{1'b0}}, h_fill_nxt};

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status        <= cmd.status;
      out_rec_passenger <= rec_sel_val.pid;
      out_rec_train     <= rec_sel_val.train;
      out_rec_fare      <= rec_sel_val.fare;
      out_history_saved <= cmd.saved;
      out_queue_count   <= q_cnt_ext[QCNT_W-1:0];
      out_history_count <= h_cnt_ext[HCNT_W-1:0];
    end
  end

endmodule

### design/ticket_queue_with_history_stack.sv
// top level of the booking queue with cancel history
// depends on tqh_pkg, tqh_ctrl and tqh_dp
//
// Usage:
//   A request word (in_req_type plus the record fields) is taken at a rising
//   edge with start high and busy low. Requests: enqueue, process head (moves
//   it to the history stack), cancel last (pops history), peek queue head,
//   peek history top. Record fields only matter for enqueue.
//   Exactly one result word follows each request: out_valid is high for one
//   cycle with status, the record, the saved flag and both counts after the
//   request. The receiver cannot stall; it must take the word that cycle.
// Timing:
//   The accept edge reads the queue head and the history top from their
//   memories, the next edge writes back and loads the result registers.
//   busy is high for one cycle between the two, and a new request is taken
//   only once busy is low again. out_valid rises at the write-back edge.
//   Each record memory is read only at the accept edge and written only
//   at the write-back edge.
// Reset:
//   rst_n (synchronous, active low) empties the queue and the history; the
//   record memories are not cleared and no result is pending after reset.
module ticket_queue_with_history_stack
  import tqh_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH   = 128,
  parameter int unsigned HISTORY_SLOTS = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [REQ_W-1:0]   in_req_type,
  input  logic [PID_W-1:0]   in_passenger_id,
  input  logic [TRAIN_W-1:0] in_train_number,
  input  logic [FARE_W-1:0]  in_fare,
  output logic               out_valid,
  output logic [STAT_W-1:0]  out_status,
  output logic [PID_W-1:0]   out_rec_passenger,
  output logic [TRAIN_W-1:0] out_rec_train,
  output logic [FARE_W-1:0]  out_rec_fare,
  output logic               out_history_saved,
  output logic [QCNT_W-1:0]  out_queue_count,
  output logic [HCNT_W-1:0]  out_history_count
);

  tqh_cmd_t   cmd;
  tqh_flags_t flags;

  // request sequencer
  tqh_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .flags       (flags),
    .cmd         (cmd),
    .busy        (busy),
    .out_valid   (out_valid)
  );

  // record storage and result registers
  tqh_dp #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .HISTORY_SLOTS (HISTORY_SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_passenger_id   (in_passenger_id),
    .in_train_number   (in_train_number),
    .in_fare           (in_fare),
    .flags             (flags),
    .out_status        (out_status),
    .out_rec_passenger (out_rec_passenger),
    .out_rec_train     (out_rec_train),
    .out_rec_fare      (out_rec_fare),
    .out_history_saved (out_history_saved),
    .out_queue_count   (out_queue_count),
    .out_history_count (out_history_count)
  );

  // every accepted word is followed by its result word
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("result word missing after accept");

  // no new word is taken while the previous one is still in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("sequencer not busy after accept");

  // a saved flag only comes with a successful process
  a_saved_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_history_saved) |-> (out_status == ST_OK))
    else $error("history saved flag with error status");

  // neither queue nor history is pushed and popped by the same request
  a_queue_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(cmd.q_push && cmd.q_pop) && !(cmd.h_push && cmd.h_pop))
    else $error("conflicting push and pop");

endmodule
